// ----- hw/rtl/frpr_pkg.sv -----
// shared constants, register indexes and types for the page replacement block
// no dependencies
`default_nettype none

package frpr_pkg;

    // build defaults
    localparam int FRAME_COUNT_DEF = 8;
    localparam int PAGE_BITS_DEF   = 16;

    // configuration port
    localparam int CFG_INDEX_W     = 4;
    localparam int CFG_DATA_W      = 4;
    localparam int FRAMES_IN_USE_W = 4;

    localparam logic [CFG_INDEX_W-1:0] REG_POLICY_MODE   = CFG_INDEX_W'(0);
    localparam logic [CFG_INDEX_W-1:0] REG_FRAMES_IN_USE = CFG_INDEX_W'(1);

    localparam logic POLICY_FIFO = 1'b0;
    localparam logic POLICY_LRU  = 1'b1;

    localparam logic [FRAMES_IN_USE_W-1:0] FRAMES_IN_USE_RST = FRAMES_IN_USE_W'(8);

    // saturating counters
    localparam int             CNT_W   = 16;
    localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

    localparam int SLOT_OUT_W = 3;

    // outcome of one lookup
    typedef struct packed {
        logic hit;
        logic fill;
        logic evict;
    } frpr_decision_t;

endpackage

`default_nettype wire

// ----- hw/rtl/frpr_lookup.sv -----
// frame match, replacement choice and recency update for one page reference
// depends on frpr_pkg
`default_nettype none

module frpr_lookup #(
    parameter int FRAME_COUNT = frpr_pkg::FRAME_COUNT_DEF,
    parameter int PAGE_BITS   = frpr_pkg::PAGE_BITS_DEF,
    localparam int SLOT_W     = (FRAME_COUNT > 1) ? $clog2(FRAME_COUNT) : 1,
    localparam int RANK_W     = SLOT_W
) (
    input  wire logic                                   policy_mode,
    input  wire logic [frpr_pkg::FRAMES_IN_USE_W-1:0]   frames_in_use,
    input  wire logic [PAGE_BITS-1:0]                   page,
    input  wire logic [FRAME_COUNT-1:0][PAGE_BITS-1:0]  frame_page,
    input  wire logic [FRAME_COUNT-1:0]                 frame_valid,
    input  wire logic [FRAME_COUNT-1:0][RANK_W-1:0]     rank,
    input  wire logic [SLOT_W-1:0]                      fifo_ptr,
    output frpr_pkg::frpr_decision_t                    decision,
    output logic [SLOT_W-1:0]                           slot,
    output logic [PAGE_BITS-1:0]                        evicted_page,
    output logic [FRAME_COUNT-1:0][RANK_W-1:0]          rank_next,
    output logic [SLOT_W-1:0]                           fifo_ptr_next
);

    localparam int NW_FC = $clog2(FRAME_COUNT + 1);
    localparam int NW    = (NW_FC > frpr_pkg::FRAMES_IN_USE_W) ?
                           NW_FC : frpr_pkg::FRAMES_IN_USE_W;

    logic [NW-1:0]          n_active;
    logic [NW-1:0]          fiu_ext;
    logic [FRAME_COUNT-1:0] active;
    logic                   found;
    logic [SLOT_W-1:0]      hit_slot;
    logic                   empty_found;
    logic [SLOT_W-1:0]      empty_slot;
    logic [SLOT_W-1:0]      fifo_slot;
    logic [SLOT_W-1:0]      lru_slot;
    logic [RANK_W-1:0]      old_rank;
    logic [NW-1:0]          slot_inc;

    // clamp the active frame count into 1..FRAME_COUNT
    always_comb
    begin
        fiu_ext = NW'(frames_in_use);
        if (fiu_ext == '0)
        begin
            n_active = NW'(1);
        end
        else if (fiu_ext > NW'(FRAME_COUNT))
        begin
            n_active = NW'(FRAME_COUNT);
        end
        else
        begin
            n_active = fiu_ext;
        end
    end

    always_comb
    begin
        for (int f = 0; f < FRAME_COUNT; f++)
        begin
            active[f] = (NW'(f) < n_active);
        end
    end

    // lowest matching frame and lowest empty frame
    always_comb
    begin
        found       = 1'b0;
        hit_slot    = '0;
        empty_found = 1'b0;
        empty_slot  = '0;
        for (int f = 0; f < FRAME_COUNT; f++)
        begin
            if (!found && active[f] && frame_valid[f] && frame_page[f] == page)
            begin
                found    = 1'b1;
                hit_slot = SLOT_W'(f);
            end
            if (!empty_found && active[f] && !frame_valid[f])
            begin
                empty_found = 1'b1;
                empty_slot  = SLOT_W'(f);
            end
        end
    end

    // oldest-loaded frame, pointer past the active range falls back to frame 0
    assign fifo_slot = (NW'(fifo_ptr) < n_active) ? fifo_ptr : '0;

    // oldest rank wins, ties go to the lowest index
    always_comb
    begin
        lru_slot = '0;
        for (int f = 1; f < FRAME_COUNT; f++)
        begin
            if (active[f] && rank[f] > rank[lru_slot])
            begin
                lru_slot = SLOT_W'(f);
            end
        end
    end

    always_comb
    begin
        decision.hit   = found;
        decision.fill  = !found && empty_found;
        decision.evict = !found && !empty_found;
        if (found)
        begin
            slot = hit_slot;
        end
        else if (empty_found)
        begin
            slot = empty_slot;
        end
        else if (policy_mode == frpr_pkg::POLICY_LRU)
        begin
            slot = lru_slot;
        end
        else
        begin
            slot = fifo_slot;
        end
    end

    assign evicted_page = decision.evict ? frame_page[slot] : '0;

    // a newly filled frame ages every other frame that is not already at the top rank
    assign old_rank = decision.fill ? RANK_W'(FRAME_COUNT - 1) : rank[slot];

    always_comb
    begin
        for (int j = 0; j < FRAME_COUNT; j++)
        begin
            if (SLOT_W'(j) == slot)
            begin
                rank_next[j] = '0;
            end
            else if (rank[j] < old_rank)
            begin
                rank_next[j] = rank[j] + RANK_W'(1);
            end
            else
            begin
                rank_next[j] = rank[j];
            end
        end
    end

    assign slot_inc      = NW'(slot) + NW'(1);
    assign fifo_ptr_next = (slot_inc == n_active) ? '0 : SLOT_W'(slot_inc);

endmodule

`default_nettype wire

// ----- hw/rtl/fifo_lru_page_replacement.sv -----
// top level of the page replacement unit: input, frame table and result registers
// depends on frpr_pkg and frpr_lookup
`default_nettype none

// Page replacement unit, FIFO or LRU policy.
// Input channel: in_valid / in_stall with page_number; a transfer happens when
// in_valid is high and in_stall low. Output channel: out_valid / out_stall with
// hit, frame_slot, evicted_valid, evicted_page, hit_total and fault_total.
// Configuration: cfg_valid / cfg_ready with cfg_index and cfg_data; index 0 is
// policy_mode (0 FIFO, 1 LRU), index 1 is frames_in_use. cfg_ready is always
// high; other indexes are ignored. Write configuration only while idle.
// A reference passes through the input register and then the result register.
// Throughput: one reference per cycle while out_stall is low, set by the single
// pass through the parallel frame match and the replacement choice between the
// input register and the result register.
// Reset empties all frames, clears recency, the FIFO pointer and both
// counters, and selects FIFO with 8 active frames.
// While out_stall holds the result, one more reference is taken into the
// input register; after that in_stall rises until the result moves on.
module fifo_lru_page_replacement #(
    parameter int FRAME_COUNT = frpr_pkg::FRAME_COUNT_DEF,
    parameter int PAGE_BITS   = frpr_pkg::PAGE_BITS_DEF
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               in_valid,
    output logic                                    in_stall,
    input  wire logic [PAGE_BITS-1:0]               page_number,
    output logic                                    out_valid,
    input  wire logic                               out_stall,
    output logic                                    hit,
    output logic [frpr_pkg::SLOT_OUT_W-1:0]         frame_slot,
    output logic                                    evicted_valid,
    output logic [PAGE_BITS-1:0]                    evicted_page,
    output logic [frpr_pkg::CNT_W-1:0]              hit_total,
    output logic [frpr_pkg::CNT_W-1:0]              fault_total,
    input  wire logic                               cfg_valid,
    output logic                                    cfg_ready,
    input  wire logic [frpr_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  wire logic [frpr_pkg::CFG_DATA_W-1:0]    cfg_data
);

    localparam int SLOT_W = (FRAME_COUNT > 1) ? $clog2(FRAME_COUNT) : 1;
    localparam int RANK_W = SLOT_W;

    logic                                       in_vld_reg;
    logic [PAGE_BITS-1:0]                       in_page_reg;
    logic                                       policy_reg;
    logic [frpr_pkg::FRAMES_IN_USE_W-1:0]       fiu_reg;
    logic [FRAME_COUNT-1:0][PAGE_BITS-1:0]      frame_page_reg;
    logic [FRAME_COUNT-1:0]                     frame_valid_reg;
    logic [FRAME_COUNT-1:0][RANK_W-1:0]         rank_reg;
    logic [FRAME_COUNT-1:0][RANK_W-1:0]         rank_next;
    logic [SLOT_W-1:0]                          fifo_ptr_reg;
    logic [SLOT_W-1:0]                          fifo_ptr_next;
    logic [frpr_pkg::CNT_W-1:0]                 hit_cnt_reg;
    logic [frpr_pkg::CNT_W-1:0]                 hit_cnt_next;
    logic [frpr_pkg::CNT_W-1:0]                 fault_cnt_reg;
    logic [frpr_pkg::CNT_W-1:0]                 fault_cnt_next;
    logic                                       out_vld_reg;
    logic                                       hit_reg;
    logic [frpr_pkg::SLOT_OUT_W-1:0]            slot_reg;
    logic                                       ev_vld_reg;
    logic [PAGE_BITS-1:0]                       ev_page_reg;

    frpr_pkg::frpr_decision_t                   decision;
    logic [SLOT_W-1:0]                          slot;
    logic [PAGE_BITS-1:0]                       ev_page;
    logic                                       advance;
    logic                                       fault;

    frpr_lookup #(
        .FRAME_COUNT (FRAME_COUNT),
        .PAGE_BITS   (PAGE_BITS)
    ) u_lookup (
        .policy_mode   (policy_reg),
        .frames_in_use (fiu_reg),
        .page          (in_page_reg),
        .frame_page    (frame_page_reg),
        .frame_valid   (frame_valid_reg),
        .rank          (rank_reg),
        .fifo_ptr      (fifo_ptr_reg),
        .decision      (decision),
        .slot          (slot),
        .evicted_page  (ev_page),
        .rank_next     (rank_next),
        .fifo_ptr_next (fifo_ptr_next)
    );

    // the held item moves into the result register when that register frees up
    assign advance  = in_vld_reg && (!out_vld_reg || !out_stall);
    assign in_stall = in_vld_reg && !advance;
    assign fault    = !decision.hit;

    assign hit_cnt_next = (decision.hit && hit_cnt_reg != frpr_pkg::CNT_MAX) ?
                          hit_cnt_reg + frpr_pkg::CNT_W'(1) : hit_cnt_reg;
    assign fault_cnt_next = (fault && fault_cnt_reg != frpr_pkg::CNT_MAX) ?
                            fault_cnt_reg + frpr_pkg::CNT_W'(1) : fault_cnt_reg;

    // configuration registers
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            policy_reg <= frpr_pkg::POLICY_FIFO;
            fiu_reg    <= frpr_pkg::FRAMES_IN_USE_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                frpr_pkg::REG_POLICY_MODE:
                begin
                    policy_reg <= cfg_data[0];
                end
                frpr_pkg::REG_FRAMES_IN_USE:
                begin
                    fiu_reg <= cfg_data[frpr_pkg::FRAMES_IN_USE_W-1:0];
                end
                default:
                begin
                end
            endcase
        end
    end

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg <= 1'b0;
        end
        else if (!in_stall)
        begin
            in_vld_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
        begin
            in_page_reg <= page_number;
        end
    end

    // frame table control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_valid_reg <= '0;
            rank_reg        <= '0;
            fifo_ptr_reg    <= '0;
            hit_cnt_reg     <= '0;
            fault_cnt_reg   <= '0;
        end
        else if (advance)
        begin
            rank_reg      <= rank_next;
            hit_cnt_reg   <= hit_cnt_next;
            fault_cnt_reg <= fault_cnt_next;
            if (fault)
            begin
                frame_valid_reg[slot] <= 1'b1;
                fifo_ptr_reg          <= fifo_ptr_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && fault)
        begin
            frame_page_reg[slot] <= in_page_reg;
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_vld_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_vld_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            hit_reg     <= decision.hit;
            slot_reg    <= frpr_pkg::SLOT_OUT_W'(slot);
            ev_vld_reg  <= decision.evict;
            ev_page_reg <= ev_page;
        end
    end

    assign out_valid     = out_vld_reg;
    assign hit           = hit_reg;
    assign frame_slot    = slot_reg;
    assign evicted_valid = ev_vld_reg;
    assign evicted_page  = ev_page_reg;
    assign hit_total     = hit_cnt_reg;
    assign fault_total   = fault_cnt_reg;

endmodule

`default_nettype wire

// ----- tb/fifo_lru_page_replacement_test.sv -----
// self-checking testbench for the fifo/lru page replacement unit: random and directed
// page references, with a frame table predictor and per-field result checks
// depends on frpr_pkg and fifo_lru_page_replacement
`default_nettype none

module fifo_lru_page_replacement_test;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int NUM_FRAMES = frpr_pkg::FRAME_COUNT_DEF;
    localparam logic [frpr_pkg::CFG_INDEX_W-1:0] REG_UNUSED_TOP = frpr_pkg::CFG_INDEX_W'(15);
    localparam int HOLD_CYCLES = 80;

    typedef struct packed {
        logic                           hit;
        logic [2:0]                     slot;
        logic                           ev_valid;
        logic [15:0]                    ev_page;
        logic [frpr_pkg::CNT_W-1:0]     hits;
        logic [frpr_pkg::CNT_W-1:0]     faults;
    } page_result_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    logic                               in_valid = 1'b0;
    logic                               in_stall;
    logic [15:0]                        page_number = '0;
    logic                               out_valid;
    logic                               out_stall = 1'b0;
    logic                               hit;
    logic [2:0]                         frame_slot;
    logic                               evicted_valid;
    logic [15:0]                        evicted_page;
    logic [frpr_pkg::CNT_W-1:0]         hit_total;
    logic [frpr_pkg::CNT_W-1:0]         fault_total;
    logic                               cfg_valid = 1'b0;
    logic                               cfg_ready;
    logic [frpr_pkg::CFG_INDEX_W-1:0]   cfg_index = '0;
    logic [frpr_pkg::CFG_DATA_W-1:0]    cfg_data = '0;

    fifo_lru_page_replacement DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .page_number   (page_number),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .hit           (hit),
        .frame_slot    (frame_slot),
        .evicted_valid (evicted_valid),
        .evicted_page  (evicted_page),
        .hit_total     (hit_total),
        .fault_total   (fault_total),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    always #4 clk = ~clk;

    // predictor state, mirrors the frame table
    logic [15:0]                    resident_page [NUM_FRAMES];
    bit                             resident_valid [NUM_FRAMES];
    int                             age_rank [NUM_FRAMES];
    int                             load_ptr = 0;
    logic [frpr_pkg::CNT_W-1:0]     hit_tally = '0;
    logic [frpr_pkg::CNT_W-1:0]     fault_tally = '0;
    logic                           policy_sel = frpr_pkg::POLICY_FIFO;
    logic [3:0]                     frames_sel = frpr_pkg::FRAMES_IN_USE_RST;

    logic [15:0]          pending_pages[$];
    page_result_t         expected_results[$];
    int                   err_count = 0;
    bit                   idle_on = 1'b1;
    int                   hold_req = 0;
    int                   hold_seen = 0;
    int                   stall_left = 0;
    int                   send_gap = 0;

    initial begin
        for (int f = 0; f < NUM_FRAMES; f++) begin
            resident_page[f] = '0;
            resident_valid[f] = 1'b0;
            age_rank[f] = 0;
        end
    end

    function automatic page_result_t lookup_page(input logic [15:0] pg);
        page_result_t r;
        int n;
        int f;
        int slot;
        int old_rank;
        int best;
        bit found;
        bit empty;
        n = (frames_sel == 0) ? 1 :
            ((frames_sel > NUM_FRAMES) ? NUM_FRAMES : int'(frames_sel));
        found = 1'b0;
        empty = 1'b0;
        slot = 0;
        r = '0;
        for (f = 0; f < n; f++)
            if (!found && resident_valid[f] && resident_page[f] == pg) begin
                slot = f;
                found = 1'b1;
            end
        if (found) begin
            r.hit = 1'b1;
            old_rank = age_rank[slot];
            if (hit_tally != frpr_pkg::CNT_MAX)
                hit_tally++;
        end
        else begin
            for (f = 0; f < n; f++)
                if (!empty && !resident_valid[f]) begin
                    slot = f;
                    empty = 1'b1;
                end
            if (empty)
                old_rank = NUM_FRAMES - 1;
            else begin
                if (policy_sel == frpr_pkg::POLICY_FIFO)
                    slot = (load_ptr < n) ? load_ptr : 0;
                else begin
                    // oldest rank wins, lowest index on ties
                    best = 0;
                    for (f = 1; f < n; f++)
                        if (age_rank[f] > age_rank[best])
                            best = f;
                    slot = best;
                end
                old_rank = age_rank[slot];
                r.ev_valid = 1'b1;
                r.ev_page = resident_page[slot];
            end
            resident_page[slot] = pg;
            resident_valid[slot] = 1'b1;
            load_ptr = (slot + 1) % n;
            if (fault_tally != frpr_pkg::CNT_MAX)
                fault_tally++;
        end
        for (f = 0; f < NUM_FRAMES; f++)
            if (f != slot && age_rank[f] < old_rank)
                age_rank[f]++;
        age_rank[slot] = 0;
        r.slot = slot[2:0];
        r.hits = hit_tally;
        r.faults = fault_tally;
        return r;
    endfunction

    task automatic check_field(input string fname, input logic [15:0] want,
                               input logic [15:0] got);
        if (got !== want) begin
            err_count++;
            if (err_count <= 40)
                $display("%0t: %s mismatch, expected %0h, got %0h", $time, fname, want, got);
        end
    endtask

    // driver: offers queued pages, predicts each transfer
    always @(posedge clk) begin
        if (!rst_n) begin
            in_valid <= 1'b0;
        end
        else begin
            if (in_valid && !in_stall)
                expected_results.push_back(lookup_page(page_number));
            if (!in_valid || !in_stall) begin
                if (send_gap > 0) begin
                    send_gap--;
                    in_valid <= 1'b0;
                end
                else if (idle_on && $urandom_range(0, 7) == 0) begin
                    send_gap = $urandom_range(0, 4);
                    in_valid <= 1'b0;
                end
                else if (pending_pages.size() > 0) begin
                    in_valid <= 1'b1;
                    page_number <= pending_pages.pop_front();
                end
                else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // monitor: checks every result transfer against the oldest prediction
    always @(posedge clk) begin
        page_result_t want;
        if (rst_n && out_valid && !out_stall) begin
            if (expected_results.size() == 0) begin
                err_count++;
                $display("%0t: result with nothing expected, actual slot %0d page %0h",
                         $time, frame_slot, evicted_page);
            end
            else begin
                want = expected_results.pop_front();
                check_field("hit", want.hit, hit);
                check_field("frame_slot", want.slot, frame_slot);
                check_field("evicted_valid", want.ev_valid, evicted_valid);
                check_field("evicted_page", want.ev_page, evicted_page);
                check_field("hit_total", want.hits, hit_total);
                check_field("fault_total", want.faults, fault_total);
            end
        end
    end

    // receiver back-pressure: short random bursts plus one long hold on request
    always @(posedge clk) begin
        if (hold_req != hold_seen) begin
            hold_seen = hold_req;
            stall_left = HOLD_CYCLES;
        end
        if (stall_left > 0) begin
            stall_left--;
            out_stall <= 1'b1;
        end
        else if (idle_on && $urandom_range(0, 7) == 0) begin
            stall_left = $urandom_range(0, 4);
            out_stall <= 1'b1;
        end
        else begin
            out_stall <= 1'b0;
        end
    end

    task automatic write_reg(input logic [frpr_pkg::CFG_INDEX_W-1:0] idx,
                             input logic [frpr_pkg::CFG_DATA_W-1:0] val);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        if (idx == frpr_pkg::REG_POLICY_MODE)
            policy_sel = val[0];
        else if (idx == frpr_pkg::REG_FRAMES_IN_USE)
            frames_sel = val[frpr_pkg::FRAMES_IN_USE_W-1:0];
        @(negedge clk);
    endtask

    // wait until every page went out and every result came back
    task automatic wait_idle();
        while (pending_pages.size() > 0 || in_valid || expected_results.size() > 0)
            @(negedge clk);
        repeat (3) @(negedge clk);
    endtask

    initial begin : stimulus
        int p;
        int i;
        int pool_base;
        int pool_size;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // fifo, all frames: fill, hits, extremes, fifo eviction
        pending_pages = {16'h0000, 16'hFFFF, 16'h0000, 16'hFFFF, 16'h5555, 16'hAAAA,
                         16'h0003, 16'h0004, 16'h0005, 16'h0006, 16'h0007, 16'hFFFF};
        wait_idle();
        // shrink: pointer wraps, inactive frame keeps a copy of a page
        write_reg(frpr_pkg::REG_FRAMES_IN_USE, 4'd2);
        pending_pages = {16'h0006, 16'h5555};
        wait_idle();
        // expand again with lru: duplicate resident page, lowest frame matches
        write_reg(frpr_pkg::REG_POLICY_MODE, frpr_pkg::CFG_DATA_W'(frpr_pkg::POLICY_LRU));
        write_reg(frpr_pkg::REG_FRAMES_IN_USE, 4'd8);
        pending_pages = {16'h5555, 16'hAAAA, 16'h0009, 16'h0003};
        wait_idle();
        // zero active frames acts as one
        write_reg(frpr_pkg::REG_FRAMES_IN_USE, 4'd0);
        pending_pages = {16'h0001, 16'h0002};
        wait_idle();
        // over-range count acts as all frames, unknown register ignored
        write_reg(frpr_pkg::REG_FRAMES_IN_USE, 4'd15);
        write_reg(REG_UNUSED_TOP, 4'hA);
        pending_pages = {16'h0002, 16'h0001};

        for (p = 0; p < 12; p++) begin
            wait_idle();
            write_reg(frpr_pkg::REG_POLICY_MODE,
                      frpr_pkg::CFG_DATA_W'($urandom_range(0, 1)));
            case (p % 4)
                0: write_reg(frpr_pkg::REG_FRAMES_IN_USE, 4'd8);
                1: write_reg(frpr_pkg::REG_FRAMES_IN_USE, 4'd1);
                default: write_reg(frpr_pkg::REG_FRAMES_IN_USE,
                                   frpr_pkg::CFG_DATA_W'($urandom_range(0, 15)));
            endcase
            if ($urandom_range(0, 2) == 0)
                write_reg(frpr_pkg::CFG_INDEX_W'($urandom_range(2, 15)),
                          frpr_pkg::CFG_DATA_W'($urandom));
            idle_on = (p < 10);
            for (i = 0; i < 150; i++) begin
                // working sets near the frame count so hits and evictions both happen
                if (i % 30 == 0) begin
                    pool_base = $urandom;
                    pool_size = $urandom_range(1, 12);
                end
                if ($urandom_range(0, 9) == 0)
                    pending_pages.push_back(16'($urandom));
                else
                    pending_pages.push_back(16'(pool_base + $urandom_range(0, pool_size - 1)));
            end
            if (p == 2)
                hold_req++;
        end

        wait_idle();
        repeat (10) @(negedge clk);

        if (err_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

    initial begin : watchdog
        #10ms;
        $display("Some tests failed");
        $finish;
    end

endmodule

`default_nettype wire
